// File: rtl/rfft_pkg.sv
package rfft_pkg;

  localparam int MAX_LOG2    = 11;
  localparam int SAMPLE_BITS = 16;
  localparam int NPTS        = 1 << MAX_LOG2;
  localparam int TWN         = NPTS / 2;
  localparam int AW          = MAX_LOG2;
  localparam int TA_W        = MAX_LOG2 - 1;
  localparam int LEN_W       = MAX_LOG2 + 1;
  localparam int DW          = 28;
  localparam int TW_W        = 17;
  localparam int LG_W        = 4;
  localparam real PI         = 3.14159265358979323846;
  localparam real TW_STEP    = 2.0 * PI / real'(NPTS);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic {
    REG_SIZE_LOG2 = 1'b0,
    REG_INVERSE   = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    WS_COPY,
    WS_BF_LO,
    WS_BF_HI,
    WS_DIV
  } wsel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CP_RD,
    ST_CP_WR,
    ST_BF_RK,
    ST_BF_RJ,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WK,
    ST_BF_WJ,
    ST_DV_RD,
    ST_DV_WR,
    ST_RD_PUT
  } state_e;

  typedef struct packed {
    opcode_e                       opcode;
    logic [AW-1:0]                 position;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] real_part;
    logic signed [DW-1:0] imag_part;
  } out_item_t;

  typedef struct packed {
    logic [LG_W-1:0] size_log2;
    logic            inverse_mode;
  } cfg_t;

  typedef struct packed {
    logic            smp_we;
    logic            smp_re;
    logic [AW-1:0]   smp_raddr;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    wsel_e           wsel;
    logic [TA_W-1:0] tw_addr;
    logic            cap_k;
    logic            mul_en;
    logic            sum_en;
    logic            out_load;
    logic            out_zero;
    logic            inv;
    logic [LG_W-1:0] lg;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  typedef logic [2*TW_W-1:0] tw_rom_t [TWN];

  // reverse over AW bits, then shift the top lg bits down to the low end
  function automatic logic [AW-1:0] rev_bits(input logic [AW-1:0] x,
                                             input logic [LG_W-1:0] lg);
    logic [AW-1:0] r;
    for (int i = 0; i < AW; i++) begin
      r[i] = x[AW-1-i];
    end
    return r >> (AW - int'(lg));
  endfunction

  // {cos, sin} in Q1.15, 1.0 kept as +32768
  function automatic tw_rom_t tw_build();
    tw_rom_t rom;
    real a;
    real c;
    real s;
    int ci;
    int si;
    for (int k = 0; k < TWN; k++) begin
      a  = TW_STEP * real'(k);
      c  = $cos(a) * 32768.0;
      s  = $sin(a) * 32768.0;
      ci = (c >= 0.0) ? $rtoi(c + 0.5) : -$rtoi(0.5 - c);
      si = (s >= 0.0) ? $rtoi(s + 0.5) : -$rtoi(0.5 - s);
      rom[k] = {TW_W'(ci), TW_W'(si)};
    end
    return rom;
  endfunction

endpackage

// File: rtl/radix2_fft_real_input.sv
// Real-input radix-2 DIT FFT, up to 2048 points, unscaled growth.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries command items:
//   load  - stores one sample.
//   run   - bit-reversed copy (a read and a write per point), then (N/2)*log2 N
//           butterflies (read k, read j, multiply, sum, write k, write j), then
//           a read and a write per point for the divide by N in inverse mode;
//           the data memory is single-port, each point read and written in turn.
//   read  - one bin; it is read into a register, then moved into the output
//           register once that register is free.
// in_stall_o is high while a run or a read is in progress. Bins read
// before any run or beyond the last run's length come back as zero.
// Output channel (out_valid_o / out_stall_i / out_data_o) is a register;
// while the receiver stalls it holds its item and the block accepts
// loads and runs, only a following read waits for the register to free.
// Size and direction are set on the APB port and take effect at the next
// run. Reset clears control and registers (size 11, forward); the
// sample and bin memories are undefined until written, no clearing pass.
module radix2_fft_real_input import rfft_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  rfft_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rfft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .cfg_i      (cfg),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rfft_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/rfft_cfg.sv
module rfft_cfg import rfft_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [LG_W-1:0] size_q;
  logic            inv_q;
  reg_e            idx;

  assign idx    = reg_e'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= LG_W'(MAX_LOG2);
      inv_q  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_SIZE_LOG2: size_q <= pwdata[LG_W-1:0];
        REG_INVERSE:   inv_q  <= pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SIZE_LOG2: prdata = {{(32-LG_W){1'b0}}, size_q};
      REG_INVERSE:   prdata = {31'b0, inv_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.size_log2    = size_q;
  assign cfg_o.inverse_mode = inv_q;

endmodule

// File: rtl/rfft_ctrl.sv
module rfft_ctrl import rfft_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_stall_o,
  input  cfg_t     cfg_i,
  input  status_t  status_i,
  output cmd_t     cmd_o
);

  state_e           state_q, state_d;
  logic [AW-1:0]    idx_q;
  logic [TA_W-1:0]  bf_q;
  logic [LG_W-1:0]  stg_q;
  logic [LG_W-1:0]  lg_q;
  logic             inv_q;
  logic [LEN_W-1:0] len_q;
  logic             zero_q;

  logic [LG_W-1:0]  lg_eff;
  logic             idx_last, bf_last, stg_last, in_acc;
  logic [TA_W-1:0]  half_mask, t_off, hi_part, tw_idx;
  logic [AW-1:0]    addr_j, addr_k;

  always_comb begin
    if (cfg_i.size_log2 == '0) lg_eff = LG_W'(1);
    else if (cfg_i.size_log2 > LG_W'(MAX_LOG2)) lg_eff = LG_W'(MAX_LOG2);
    else lg_eff = cfg_i.size_log2;
  end

  assign idx_last  = idx_q == ({AW{1'b1}} >> (AW - int'(lg_q)));
  assign bf_last   = bf_q == ({TA_W{1'b1}} >> (AW - int'(lg_q)));
  assign stg_last  = stg_q == (lg_q - LG_W'(1));

  // pair addresses for butterfly bf_q of stage stg_q
  assign half_mask = ~({TA_W{1'b1}} << stg_q);
  assign t_off     = bf_q & half_mask;
  assign hi_part   = bf_q & ~half_mask;
  assign addr_j    = {hi_part, 1'b0} | {1'b0, t_off};
  assign addr_k    = addr_j | (AW'(1) << stg_q);
  assign tw_idx    = t_off << (TA_W - int'(stg_q));

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.opcode)
            OP_RUN:  state_d = ST_CP_RD;
            OP_READ: state_d = ST_RD_PUT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CP_RD:  state_d = ST_CP_WR;
      ST_CP_WR:  state_d = idx_last ? ST_BF_RK : ST_CP_RD;
      ST_BF_RK:  state_d = ST_BF_RJ;
      ST_BF_RJ:  state_d = ST_BF_MUL;
      ST_BF_MUL: state_d = ST_BF_SUM;
      ST_BF_SUM: state_d = ST_BF_WK;
      ST_BF_WK:  state_d = ST_BF_WJ;
      ST_BF_WJ: begin
        if (bf_last && stg_last) state_d = inv_q ? ST_DV_RD : ST_IDLE;
        else state_d = ST_BF_RK;
      end
      ST_DV_RD:  state_d = ST_DV_WR;
      ST_DV_WR:  state_d = idx_last ? ST_IDLE : ST_DV_RD;
      ST_RD_PUT: state_d = status_i.out_free ? ST_IDLE : ST_RD_PUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.inv       = inv_q;
    cmd_o.lg        = lg_q;
    cmd_o.smp_raddr = idx_q;
    cmd_o.tw_addr   = tw_idx;
    cmd_o.wsel      = WS_COPY;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.opcode)
            OP_LOAD: cmd_o.smp_we = 1'b1;
            OP_READ: begin
              cmd_o.mem_re    = 1'b1;
              cmd_o.mem_raddr = in_data_i.position;
            end
            default: ;
          endcase
        end
      end
      ST_CP_RD: cmd_o.smp_re = 1'b1;
      ST_CP_WR: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_waddr = rev_bits(idx_q, lg_q);
      end
      ST_BF_RK: begin
        cmd_o.mem_re    = 1'b1;
        cmd_o.mem_raddr = addr_k;
      end
      ST_BF_RJ: begin
        cmd_o.mem_re    = 1'b1;
        cmd_o.mem_raddr = addr_j;
        cmd_o.cap_k     = 1'b1;
      end
      ST_BF_MUL: cmd_o.mul_en = 1'b1;
      ST_BF_SUM: cmd_o.sum_en = 1'b1;
      ST_BF_WK: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_waddr = addr_k;
        cmd_o.wsel      = WS_BF_LO;
      end
      ST_BF_WJ: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_waddr = addr_j;
        cmd_o.wsel      = WS_BF_HI;
      end
      ST_DV_RD: begin
        cmd_o.mem_re    = 1'b1;
        cmd_o.mem_raddr = idx_q;
      end
      ST_DV_WR: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_waddr = idx_q;
        cmd_o.wsel      = WS_DIV;
      end
      ST_RD_PUT: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_zero = zero_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      bf_q    <= '0;
      stg_q   <= '0;
      lg_q    <= LG_W'(1);
      inv_q   <= 1'b0;
      len_q   <= '0;
      zero_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && in_data_i.opcode == OP_RUN) begin
            lg_q  <= lg_eff;
            inv_q <= cfg_i.inverse_mode;
            idx_q <= '0;
            bf_q  <= '0;
            stg_q <= '0;
          end
          if (in_acc && in_data_i.opcode == OP_READ) begin
            zero_q <= {1'b0, in_data_i.position} >= len_q;
          end
        end
        ST_CP_WR, ST_DV_WR: idx_q <= idx_last ? '0 : idx_q + AW'(1);
        ST_BF_WJ: begin
          if (bf_last) begin
            bf_q  <= '0;
            stg_q <= stg_q + LG_W'(1);
            if (stg_last) len_q <= LEN_W'(1) << lg_q;
          end else begin
            bf_q <= bf_q + TA_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("result loaded while output register busy");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.opcode == OP_RUN) |=> state_q == ST_CP_RD)
    else $error("run item did not start the copy pass");

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.mem_we && cmd_o.mem_re))
    else $error("data memory read and write in one cycle");

endmodule

// File: rtl/rfft_dp.sv
module rfft_dp import rfft_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  localparam int PW = TW_W + DW;
  localparam logic signed [PW-1:0] RND = PW'(16384);
  localparam tw_rom_t TwRom = tw_build();

  logic signed [SAMPLE_BITS-1:0] smp_mem [NPTS];
  logic [2*DW-1:0]               dat_mem [NPTS];

  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic [2*DW-1:0]               rd_q, xk_q, xj_q;
  logic [2*TW_W-1:0]             tw_q;
  logic signed [PW-1:0]          p_rr_q, p_ii_q, p_ir_q, p_ri_q;
  logic signed [DW-1:0]          tr_q, ti_q;
  logic                          out_valid_q;
  out_item_t                     out_q;

  logic signed [TW_W-1:0] wr, sn, wi;
  logic signed [DW-1:0]   xkr, xki, xjr, xji, rdr, rdi;
  logic signed [PW-1:0]   r_rr, r_ii, r_ir, r_ri;
  logic [2*DW-1:0]        wdata;

  function automatic logic signed [DW-1:0] div_n(input logic signed [DW-1:0] v,
                                                 input logic [LG_W-1:0] lg);
    logic [DW-1:0] bias;
    bias = v[DW-1] ? DW'({AW{1'b1}} >> (AW - int'(lg))) : '0;
    return (v + $signed(bias)) >>> lg;
  endfunction

  assign wr  = $signed(tw_q[2*TW_W-1:TW_W]);
  assign sn  = $signed(tw_q[TW_W-1:0]);
  assign wi  = cmd_i.inv ? -sn : sn;
  assign xkr = $signed(xk_q[2*DW-1:DW]);
  assign xki = $signed(xk_q[DW-1:0]);
  assign xjr = $signed(xj_q[2*DW-1:DW]);
  assign xji = $signed(xj_q[DW-1:0]);
  assign rdr = $signed(rd_q[2*DW-1:DW]);
  assign rdi = $signed(rd_q[DW-1:0]);

  // round to nearest at 2^15, ties up
  assign r_rr = (p_rr_q + RND) >>> 15;
  assign r_ii = (p_ii_q + RND) >>> 15;
  assign r_ir = (p_ir_q + RND) >>> 15;
  assign r_ri = (p_ri_q + RND) >>> 15;

  always_comb begin
    case (cmd_i.wsel)
      WS_COPY:  wdata = {DW'(smp_q), {DW{1'b0}}};
      WS_BF_LO: wdata = {xjr - tr_q, xji - ti_q};
      WS_BF_HI: wdata = {xjr + tr_q, xji + ti_q};
      WS_DIV:   wdata = {div_n(rdr, cmd_i.lg), div_n(rdi, cmd_i.lg)};
      default:  wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_we) smp_mem[in_data_i.position] <= in_data_i.sample;
    if (cmd_i.smp_re) smp_q <= smp_mem[cmd_i.smp_raddr];
    if (cmd_i.mem_we) dat_mem[cmd_i.mem_waddr] <= wdata;
    if (cmd_i.mem_re) rd_q <= dat_mem[cmd_i.mem_raddr];
    tw_q <= TwRom[cmd_i.tw_addr];
    if (cmd_i.cap_k) xk_q <= rd_q;
    if (cmd_i.mul_en) begin
      xj_q   <= rd_q;
      p_rr_q <= wr * xkr;
      p_ii_q <= wi * xki;
      p_ir_q <= wi * xkr;
      p_ri_q <= wr * xki;
    end
    if (cmd_i.sum_en) begin
      tr_q <= r_rr[DW-1:0] - r_ii[DW-1:0];
      ti_q <= r_ir[DW-1:0] + r_ri[DW-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.real_part <= cmd_i.out_zero ? '0 : rdr;
      out_q.imag_part <= cmd_i.out_zero ? '0 : rdi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule
